@@ design/fixed_block_pool_allocator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the slot pool allocator
// Shared concurrent assertion shorthands, clocked, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// Property checked at every rising edge outside reset.
`define FBPA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbpa assertion failed");

// Property checked at every rising edge, reset included.
`define FBPA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fbpa assertion failed");

`endif

@@ design/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Sizes, codes and shared types for the allocator core.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int Slots  = 1024;
  localparam int SlotW  = 10;
  localparam int CntW   = 11;
  localparam int ChunkW = 11;

  localparam logic [ChunkW-1:0] ChunkReset = ChunkW'(10);

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // One word per slot: allocated flag, list-continues flag, successor.
  typedef struct packed {
    logic             alloc;
    logic             more;
    logic [SlotW-1:0] link;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic [SlotW-1:0] granted;
    status_e          status;
  } res_t;

endpackage

@@ design/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int Depth = 1024,
  parameter int Width = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slot pool allocator control
// Two-step sequencer: read slot word, then update pointers and write back.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [fbpa_pkg::SlotW-1:0] slot_index_i,
  input  logic [fbpa_pkg::ChunkW-1:0] grow_step_i,
  input  logic                       res_ready_i,
  output logic                       res_valid_o,
  output fbpa_pkg::res_t             res_o
);

  import fbpa_pkg::*;

  state_e state_q, state_d;
  logic              mode_q;
  logic [SlotW-1:0]  idx_q;
  logic [SlotW-1:0]  head_q, head_d;
  logic              nonempty_q, nonempty_d;
  logic [CntW-1:0]   fresh_q, fresh_d;
  logic [CntW-1:0]   prov_q, prov_d;

  logic              accept;
  logic              ram_re;
  logic [SlotW-1:0]  ram_raddr;
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  entry_t            wr_entry;
  logic [EntryW-1:0] ram_rdata;
  entry_t            rd_entry;
  logic [CntW-1:0]   step;
  logic [CntW:0]     grow_end;

  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign ram_re    = accept;
  assign ram_raddr = (mode_i == ModeFree) ? slot_index_i : head_q;
  assign rd_entry  = entry_t'(ram_rdata);
  assign step      = (grow_step_i == '0) ? CntW'(1) : CntW'(grow_step_i);
  assign grow_end  = {1'b0, prov_q} + {1'b0, step};

  fbpa_ram #(
    .Depth (Slots),
    .Width (EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      nonempty_q <= 1'b0;
      fresh_q    <= '0;
      prov_q     <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      fresh_q    <= fresh_d;
      prov_q     <= prov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      idx_q  <= slot_index_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    nonempty_d  = nonempty_q;
    fresh_d     = fresh_q;
    prov_d      = prov_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    wr_entry    = '0;
    res_valid_o = 1'b0;
    res_o       = '{granted: '0, status: STATUS_OK};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (res_ready_i) begin
          state_d     = ST_IDLE;
          res_valid_o = 1'b1;
          if (mode_q == ModeFree) begin
            // fresh_q bounds the slots ever handed out; from it upward the word is unwritten
            if (({1'b0, idx_q} < fresh_q) && rd_entry.alloc) begin
              ram_we     = 1'b1;
              ram_waddr  = idx_q;
              wr_entry   = '{alloc: 1'b0, more: nonempty_q, link: head_q};
              head_d     = idx_q;
              nonempty_d = 1'b1;
            end else begin
              res_o.status = STATUS_BAD_FREE;
            end
          end else if (nonempty_q) begin
            ram_we        = 1'b1;
            ram_waddr     = head_q;
            wr_entry      = '{alloc: 1'b1, more: rd_entry.more, link: rd_entry.link};
            head_d        = rd_entry.link;
            nonempty_d    = rd_entry.more;
            res_o.granted = head_q;
          end else if ((fresh_q >= prov_q) && (grow_end > (CntW+1)'(Slots))) begin
            res_o.status = STATUS_NO_SPACE;
          end else begin
            if (fresh_q >= prov_q) begin
              prov_d = grow_end[CntW-1:0];
            end
            ram_we        = 1'b1;
            ram_waddr     = fresh_q[SlotW-1:0];
            wr_entry      = '{alloc: 1'b1, more: 1'b0, link: '0};
            fresh_d       = fresh_q + CntW'(1);
            res_o.granted = fresh_q[SlotW-1:0];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/fixed_block_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Fixed block pool allocator core
// Hands out and takes back equal-size slots by index.
// ----------------------------------------------------------------------------
// Request channel: in_valid_i / in_stall_o with mode_i (0 allocate, 1 free)
// and slot_index_i (slot to free). Result channel: out_valid_o / out_stall_i
// with granted_slot_o and status_o (0 ok, 1 out of space, 2 bad free).
// A transfer happens on a rising edge with valid high and stall low.
// Each request is done in steps: the slot word is read from the slot RAM
// (one read port, registered read data), then the free-list head and pool
// pointers are updated and the word is written back. A new request is only
// taken once the second step of the last one is done, and the result is
// registered at the end of that step. A request is taken while a result
// still waits; if the result register stays stalled the second step holds
// until it drains. The chunk size is written through cfg_we_i / cfg_wdata_i
// while idle; the user must keep to this, the block does not enforce it.
// Reset empties the pool and the free list and sets the chunk size to 10;
// no clearing pass is needed, requests are taken straight after reset.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_core_macros.svh"

module fixed_block_pool_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbpa_pkg::ChunkW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [fbpa_pkg::SlotW-1:0]  slot_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fbpa_pkg::SlotW-1:0]  granted_slot_o,
  output logic [1:0]                  status_o
);

  import fbpa_pkg::*;

  logic [ChunkW-1:0] chunk_q;
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q;
  logic              res_ready;
  logic              res_valid;
  res_t              res;
  logic              fail_reply;

  assign res_ready = !out_valid_q || !out_stall_i;

  fbpa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .slot_index_i (slot_index_i),
    .grow_step_i  (chunk_q),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= ChunkReset;
    end else if (cfg_we_i) begin
      chunk_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = out_res_q.granted;
  assign status_o       = out_res_q.status;

  assign fail_reply = out_valid_o && (status_o != STATUS_OK);

  `FBPA_ASSERT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  `FBPA_ASSERT(a_fail_grants_zero, clk_i, rst_ni, fail_reply |-> granted_slot_o == '0)
  `FBPA_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))
  `FBPA_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o)

endmodule
